// ----- rtl/core/ssq_pkg.sv -----
// Shared types and constants for the stable sorted priority queue.
// No dependencies; imported by ssq_cell and stable_sorted_priority_queue.
`timescale 1ns / 1ps

package ssq_pkg;

  // sizing
  localparam int QUEUE_DEPTH = 512;
  localparam int WEIGHT_BITS = 32;
  localparam int TAG_BITS    = 16;
  localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  // operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // one held entry
  typedef struct packed {
    logic [TAG_BITS-1:0]    tag;
    logic [WEIGHT_BITS-1:0] weight;
  } entry_t;

  // request payload
  typedef struct packed {
    logic [1:0]             func;
    logic [TAG_BITS-1:0]    in_tag;
    logic [WEIGHT_BITS-1:0] in_weight;
  } req_t;

  // result payload
  typedef struct packed {
    logic [TAG_BITS-1:0]    out_tag;
    logic [WEIGHT_BITS-1:0] out_weight;
    logic                   out_valid;
    logic [COUNT_BITS-1:0]  entry_count;
    logic [1:0]             status;
  } rsp_t;

  // broadcast control for the row of cells
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

// ----- rtl/core/stable_sorted_priority_queue.sv -----
// Stable sorted priority queue built from a row of shifting cells.
// The result strobe is registered and comes in the cycle after the request is taken.
// Throughput: 1 request per cycle; every cell compares and shifts at once, so busy stays low.
// Reset: clears the entry count and the result strobe; cell contents are left undefined.
// Results cannot be stalled: each is shown for exactly one cycle on done.
// Depends on ssq_pkg and ssq_cell.
`timescale 1ns / 1ps

module stable_sorted_priority_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ssq_pkg::req_t req,
  output logic          done,
  output ssq_pkg::rsp_t rsp
);
  import ssq_pkg::*;

  localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_DEPTH);

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  cell_ctl_t             ctl;
  rsp_t                  rsp_next;
  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH-1:0] le;
  entry_t                cells [QUEUE_DEPTH];

  // request handshake
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == FULL_COUNT);
  assign empty  = (count == '0);

  // broadcast control
  always_comb begin
    ctl.ins              = accept && (req.func == FUNC_INSERT) && !full;
    ctl.rem              = accept && (req.func == FUNC_REMOVE) && !empty;
    ctl.new_entry.tag    = req.in_tag;
    ctl.new_entry.weight = req.in_weight;
  end

  // row of cells, slot 0 holds the lowest weight
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign occ[i] = (COUNT_BITS'(i) < count);

    if (i == 0) begin : g_head
      ssq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occ         (occ[i]),
        .left_le     (1'b1),
        .left_entry  (ctl.new_entry),
        .right_entry (cells[i+1]),
        .le          (le[i]),
        .entry       (cells[i])
      );
    end else if (i == QUEUE_DEPTH - 1) begin : g_tail
      ssq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occ         (occ[i]),
        .left_le     (le[i-1]),
        .left_entry  (cells[i-1]),
        .right_entry (cells[i]),
        .le          (le[i]),
        .entry       (cells[i])
      );
    end else begin : g_mid
      ssq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occ         (occ[i]),
        .left_le     (le[i-1]),
        .left_entry  (cells[i-1]),
        .right_entry (cells[i+1]),
        .le          (le[i]),
        .entry       (cells[i])
      );
    end
  end

  // count update and result build
  always_comb begin
    count_next  = count;
    rsp_next    = '0;
    case (req.func)
      FUNC_INSERT: begin
        if (full) begin
          rsp_next.status = STATUS_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (empty) begin
          rsp_next.status = STATUS_EMPTY;
        end else begin
          count_next          = count - 1'b1;
          rsp_next.out_tag    = cells[0].tag;
          rsp_next.out_weight = cells[0].weight;
          rsp_next.out_valid  = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
    rsp_next.entry_count = count_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // every taken request gives exactly one result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("taken request gave no result");

  // the two lowest slots stay in order
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (count > COUNT_BITS'(1)) |-> (cells[0].weight <= cells[1].weight))
    else $error("head of queue out of order");

  // a dropped insert leaves the queue full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == STATUS_FULL) |-> (rsp.entry_count == FULL_COUNT))
    else $error("insert dropped while not full");

  // a returned entry means the queue was not empty and lost one
  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (accept && ctl.rem) |=> (done && rsp.out_valid && count == $past(count) - 1'b1))
    else $error("remove did not return an entry");

endmodule

// ----- rtl/core/ssq_cell.sv -----
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
// Depends on ssq_pkg.
`timescale 1ns / 1ps

module ssq_cell (
  input  logic              clk,
  input  ssq_pkg::cell_ctl_t ctl,
  input  logic              occ,
  input  logic              left_le,
  input  ssq_pkg::entry_t   left_entry,
  input  ssq_pkg::entry_t   right_entry,
  output logic              le,
  output ssq_pkg::entry_t   entry
);
  import ssq_pkg::*;

  entry_t entry_next;

  // held entry goes no later than the new one (keeps arrival order on ties)
  assign le = occ && (entry.weight <= ctl.new_entry.weight);

  // insert opens a gap at the first greater slot, remove shifts toward slot 0
  always_comb begin
    entry_next = entry;
    if (ctl.ins) begin
      if (le) begin
        entry_next = entry;
      end else if (left_le) begin
        entry_next = ctl.new_entry;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctl.rem) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
